/* src/hkse_pkg.sv */
// Shared types and constants for the hashed key set engine.
`default_nettype none

package hkse_pkg;

    localparam int KEY_W       = 31;
    localparam int OPC_W       = 2;
    localparam int STAT_W      = 2;
    localparam int BIDX_W      = 6;
    localparam int CNT_OUT_W   = 9;
    localparam int BUCKETS_DEF = 64;
    localparam int SLOTS_DEF   = 4;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_EXISTS = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RECIP,
        S_BACK,
        S_REDUCE,
        S_READ,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic recip;
        logic back;
        logic reduce;
        logic update;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* src/hkse_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hkse_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/hkse_ctrl.sv */
// Controller state machine of the hashed key set engine.
`default_nettype none

module hkse_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_result_strobe,
    output hkse_pkg::t_dp_cmd      o_cmd,
    input  wire hkse_pkg::t_dp_stat i_stat
);
    import hkse_pkg::*;

    t_state r_state, n_state;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_UPDATE);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RECIP;
                end
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = S_BACK;
            end
            S_BACK: begin
                o_cmd.back = 1'b1;
                n_state    = S_REDUCE;
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                // The bucket row is read from memory during this cycle.
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;

endmodule

`default_nettype wire

/* src/hkse_dpath.sv */
// Datapath: bucket selection, bucket row memory, slot compare and update.
`default_nettype none

module hkse_dpath #(
    parameter int BUCKETS = hkse_pkg::BUCKETS_DEF,
    parameter int SLOTS   = hkse_pkg::SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [hkse_pkg::OPC_W-1:0]    i_opcode,
    input  wire logic [hkse_pkg::KEY_W-1:0]    i_user_key,
    input  wire hkse_pkg::t_dp_cmd             i_cmd,
    output hkse_pkg::t_dp_stat                 o_stat,
    output logic      [hkse_pkg::STAT_W-1:0]   o_status,
    output logic      [hkse_pkg::BIDX_W-1:0]   o_bucket_index,
    output logic      [hkse_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import hkse_pkg::*;

    localparam int BA_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SHIFT   = KEY_W + $clog2(BUCKETS);
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam int ROW_W   = SLOTS * (KEY_W + 1);
    localparam int CNT_W   = $clog2(BUCKETS * SLOTS + 1);
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [KEY_W-1:0]   BUCKETS_K = KEY_W'(BUCKETS);
    localparam logic [BA_W-1:0]    LAST_ROW  = BA_W'(BUCKETS - 1);

    logic [OPC_W-1:0]  r_opcode;
    logic [KEY_W-1:0]  r_key;
    logic [PROD_W-1:0] r_prod;
    logic [KEY_W-1:0]  r_qb;
    logic [BA_W-1:0]   r_bucket;
    logic [BA_W-1:0]   r_clr_addr;
    logic [CNT_W-1:0]  r_count, n_count;
    t_status           r_status, n_status;

    logic [KEY_W-1:0]  quot;
    logic [KEY_W-1:0]  rem;
    logic [ROW_W-1:0]  rd_row, wr_row, ram_wdata;
    logic [BA_W-1:0]   ram_waddr;
    logic              ram_we, row_we;
    logic [SLOTS-1:0]  valid_v, hit_v, hit_oh, free_oh;
    logic              any_hit, has_free;

    // Key modulo BUCKETS by a reciprocal multiply: the quotient estimate is
    // low by at most one, so a single compare and subtract finishes it.
    assign quot = KEY_W'(r_prod >> SHIFT);
    assign rem  = r_key - r_qb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_key    <= i_user_key;
        end
        if (i_cmd.recip) begin
            r_prod <= PROD_W'(r_key) * PROD_W'(RECIP);
        end
        if (i_cmd.back) begin
            r_qb <= quot * BUCKETS_K;
        end
        if (i_cmd.reduce) begin
            r_bucket <= (rem >= BUCKETS_K) ? BA_W'(rem - BUCKETS_K) : BA_W'(rem);
        end
        if (i_cmd.update) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + BA_W'(1);
            end
            if (i_cmd.update) begin
                r_count <= n_count;
            end
        end
    end

    // Row layout: the valid bits sit above the packed slot keys.
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            valid_v[s] = rd_row[SLOTS*KEY_W + s];
            hit_v[s]   = valid_v[s] && (rd_row[s*KEY_W +: KEY_W] == r_key);
        end
        hit_oh   = hit_v & (~hit_v + SLOTS'(1));
        free_oh  = ~valid_v & (valid_v + SLOTS'(1));
        any_hit  = |hit_v;
        has_free = |free_oh;
    end

    always_comb begin
        wr_row   = rd_row;
        row_we   = 1'b0;
        n_status = ST_ABSENT;
        n_count  = r_count;
        unique case (t_opcode'(r_opcode))
            OP_INSERT: begin
                if (any_hit) begin
                    n_status = ST_EXISTS;
                end else if (!has_free) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                    row_we   = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    for (int s = 0; s < SLOTS; s++) begin
                        if (free_oh[s]) begin
                            wr_row[s*KEY_W +: KEY_W]  = r_key;
                            wr_row[SLOTS*KEY_W + s]   = 1'b1;
                        end
                    end
                end
            end
            OP_LOOKUP: begin
                n_status = any_hit ? ST_DONE : ST_ABSENT;
            end
            OP_REMOVE: begin
                if (any_hit) begin
                    n_status = ST_DONE;
                    row_we   = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                    for (int s = 0; s < SLOTS; s++) begin
                        if (hit_oh[s]) begin
                            wr_row[SLOTS*KEY_W + s] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_status = ST_ABSENT;
            end
        endcase
    end

    assign ram_we    = i_cmd.clear || (i_cmd.update && row_we);
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_bucket;
    assign ram_wdata = i_cmd.clear ? '0 : wr_row;

    hkse_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_bucket),
        .o_rdata (rd_row)
    );

    assign o_stat.clear_last = (r_clr_addr == LAST_ROW);
    assign o_status          = r_status;
    assign o_bucket_index    = BIDX_W'(r_bucket);
    assign o_entry_count     = CNT_OUT_W'(r_count);

endmodule

`default_nettype wire

/* src/hashed_key_set_engine_unit.sv */
// Top level of the hashed key set engine: controller plus datapath.
`default_nettype none

// A set of 31-bit keys in BUCKETS buckets of SLOTS slots each. After reset
// the block runs a clearing pass over the bucket memory, one row a cycle,
// with busy high. An operation is taken when start is high and busy is
// low; its single result appears on o_status, o_bucket_index and
// o_entry_count with o_result_strobe high for exactly one cycle, and must
// be captured then since the block cannot be stalled. A new request can be
// taken in the same cycle as that strobe, but not before it, since busy
// stays high until the result is out. The states S_RECIP, S_BACK and
// S_REDUCE work out the bucket by a reciprocal multiply, S_READ reads the
// bucket row from memory, and S_UPDATE compares all slots and writes the
// row back when an insert or remove changes it. o_bucket_index and
// o_entry_count are the low bits of the bucket and of the live key count.
module hashed_key_set_engine_unit #(
    parameter int BUCKETS = hkse_pkg::BUCKETS_DEF,
    parameter int SLOTS   = hkse_pkg::SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [hkse_pkg::OPC_W-1:0]     i_opcode,
    input  wire logic [hkse_pkg::KEY_W-1:0]     i_user_key,
    output logic                                o_result_strobe,
    output logic      [hkse_pkg::STAT_W-1:0]    o_status,
    output logic      [hkse_pkg::BIDX_W-1:0]    o_bucket_index,
    output logic      [hkse_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import hkse_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hkse_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .o_result_strobe (o_result_strobe),
        .o_cmd           (cmd),
        .i_stat          (stat)
    );

    hkse_dpath #(
        .BUCKETS (BUCKETS),
        .SLOTS   (SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_opcode),
        .i_user_key     (i_user_key),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_bucket_index (o_bucket_index),
        .o_entry_count  (o_entry_count)
    );

endmodule

`default_nettype wire

/* src/hkse_chk.sv */
// Port-level checker for the hashed key set engine, bound to the top level.
`default_nettype none

module hkse_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_result_strobe
);

    // Every taken request is answered after a fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_result_strobe)
        else $error("result strobe missing six cycles after a request");

    // A result is only shown once the engine is ready again.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobe while busy");

    // One request gives one result.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for more than one cycle");

    // A taken request occupies the engine.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after taking a request");

endmodule

bind hashed_key_set_engine_unit hkse_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe)
);

`default_nettype wire
